// ----- sv/bdpc_pkg.sv -----
// Package for the button debounce and press classifier.
// Holds widths, register indexes, reset values and the config/result structs.
// No dependencies; every other file uses it by scoped names.
package bdpc_pkg;

    // Widths of the stored state
    localparam int PRESS_TIMER_BITS = 16;
    localparam int CHANGE_BITS      = 10;
    localparam int DEBOUNCE_BITS    = 10;
    localparam int LONG_BITS        = 16;
    localparam int MODE_BITS        = 5;
    localparam int EVENT_BITS       = 2;

    // Compare width for press duration against the long-press time
    localparam int CMP_BITS = (PRESS_TIMER_BITS > LONG_BITS) ? PRESS_TIMER_BITS : LONG_BITS;

    // Configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_DEBOUNCE   = 2'd0,
        CFG_LONG_PRESS = 2'd1,
        CFG_LAST_MODE  = 2'd2
    } t_cfg_index;

    // Register reset values
    localparam logic [DEBOUNCE_BITS-1:0] DEBOUNCE_RESET   = DEBOUNCE_BITS'(50);
    localparam logic [LONG_BITS-1:0]     LONG_PRESS_RESET = LONG_BITS'(10000);
    localparam logic [MODE_BITS-1:0]     LAST_MODE_RESET  = MODE_BITS'(21);

    // Event codes
    typedef enum logic [EVENT_BITS-1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2
    } t_event;

    // Pin levels (active-low button)
    localparam logic LEVEL_RELEASED = 1'b1;
    localparam logic LEVEL_PRESSED  = 1'b0;

    typedef struct packed {
        logic [DEBOUNCE_BITS-1:0] debounce_ticks;
        logic [LONG_BITS-1:0]     long_press_ticks;
        logic [MODE_BITS-1:0]     last_mode;
    } t_cfg;

    typedef struct packed {
        t_event               event_kind;
        logic [MODE_BITS-1:0] mode_number;
        logic                 stable_level;
    } t_result;

endpackage

// ----- sv/bdpc_intf.sv -----
// Handshake interfaces for the button debounce and press classifier.
// Sample stream in, result stream out, register write channel.
// Depends on bdpc_pkg.
interface bdpc_in_if;
    logic valid;
    logic ready;
    logic button_level;

    modport source (output valid, output button_level, input ready);
    modport sink   (input valid, input button_level, output ready);
endinterface

interface bdpc_out_if;
    logic                           valid;
    logic                           ready;
    logic [bdpc_pkg::EVENT_BITS-1:0] event_kind;
    logic [bdpc_pkg::MODE_BITS-1:0]  mode_number;
    logic                           stable_level;

    modport source (output valid, output event_kind, output mode_number,
                    output stable_level, input ready);
    modport sink   (input valid, input event_kind, input mode_number,
                    input stable_level, output ready);
endinterface

interface bdpc_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [bdpc_pkg::CFG_INDEX_BITS-1:0] index;
    logic [bdpc_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/button_debounce_press_classifier_unit.sv -----
// Button debounce and short/long press classifier, top level.
// A sample goes through the input register, then the result register.
// Throughput: one sample per cycle while o_res.ready is high; the input
// and result registers each hand off in the cycle the next frees up.
// Reset (synchronous, active low): state to released, counters to zero,
// registers to their defaults; both stages empty. Depends on bdpc_pkg.
module button_debounce_press_classifier_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bdpc_in_if.sink   i_in,
    bdpc_out_if.source o_res,
    bdpc_cfg_if.sink  i_cfg
);

    logic              r_in_vld;
    logic              r_in_level;
    logic              r_out_vld;
    bdpc_pkg::t_result r_out;

    logic              advance;
    logic              in_take;
    bdpc_pkg::t_cfg    cfg;
    bdpc_pkg::t_result result;

    // Register writes are always taken
    assign i_cfg.ready = 1'b1;

    bdpc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg.valid),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (cfg)
    );

    // Move a sample forward when the result register is free or draining
    assign advance    = r_in_vld && (!r_out_vld || o_res.ready);
    assign i_in.ready = !r_in_vld || advance;
    assign in_take    = i_in.valid && i_in.ready;

    bdpc_tick_engine u_tick_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_advance(advance),
        .i_level  (r_in_level),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_level <= i_in.button_level;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_res.valid        = r_out_vld;
    assign o_res.event_kind   = r_out.event_kind;
    assign o_res.mode_number  = r_out.mode_number;
    assign o_res.stable_level = r_out.stable_level;

    // A short press is only reported on a release
    a_short_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.event_kind == bdpc_pkg::EV_SHORT)
        |-> (r_out.stable_level == bdpc_pkg::LEVEL_RELEASED))
        else $error("short press reported while level is pressed");

    // A long press is only reported while held
    a_long_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.event_kind == bdpc_pkg::EV_LONG)
        |-> (r_out.stable_level == bdpc_pkg::LEVEL_PRESSED))
        else $error("long press reported while level is released");

    // Input stalls only while a sample waits in the input register
    a_stall_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_in_vld && r_out_vld && !o_res.ready))
        else $error("input stalled without a blocked sample");

    // Every advance leaves a result word behind
    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_vld)
        else $error("advanced sample did not reach the result register");

endmodule

// ----- sv/bdpc_cfg_regs.sv -----
// Configuration registers: debounce time, long-press time, last mode.
// Writes at unknown indexes are dropped. Depends on bdpc_pkg.
module bdpc_cfg_regs (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  logic [bdpc_pkg::CFG_INDEX_BITS-1:0] i_index,
    input  logic [bdpc_pkg::CFG_DATA_BITS-1:0]  i_data,
    output bdpc_pkg::t_cfg  o_cfg
);

    bdpc_pkg::t_cfg r_cfg;

    // Decode the index and load the addressed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks   <= bdpc_pkg::DEBOUNCE_RESET;
            r_cfg.long_press_ticks <= bdpc_pkg::LONG_PRESS_RESET;
            r_cfg.last_mode        <= bdpc_pkg::LAST_MODE_RESET;
        end else if (i_wr) begin
            unique case (bdpc_pkg::t_cfg_index'(i_index))
                bdpc_pkg::CFG_DEBOUNCE: begin
                    r_cfg.debounce_ticks <= i_data[bdpc_pkg::DEBOUNCE_BITS-1:0];
                end
                bdpc_pkg::CFG_LONG_PRESS: begin
                    r_cfg.long_press_ticks <= i_data[bdpc_pkg::LONG_BITS-1:0];
                end
                bdpc_pkg::CFG_LAST_MODE: begin
                    r_cfg.last_mode <= i_data[bdpc_pkg::MODE_BITS-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- sv/bdpc_tick_engine.sv -----
// Per-tick state update: change counter, debounced level, press timer,
// long-press flag and mode counter. Depends on bdpc_pkg.
module bdpc_tick_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  logic               i_level,
    input  bdpc_pkg::t_cfg     i_cfg,
    output bdpc_pkg::t_result  o_result
);

    localparam logic [bdpc_pkg::CHANGE_BITS-1:0] CHANGE_MAX = '1;
    localparam logic [bdpc_pkg::PRESS_TIMER_BITS-1:0] PRESS_MAX = '1;

    logic                                  r_prev_raw;
    logic [bdpc_pkg::CHANGE_BITS-1:0]      r_change;
    logic                                  r_stable;
    logic [bdpc_pkg::PRESS_TIMER_BITS-1:0] r_press;
    logic                                  r_long_done;
    logic [bdpc_pkg::MODE_BITS-1:0]        r_mode;

    logic [bdpc_pkg::CHANGE_BITS-1:0]      n_change;
    logic                                  n_stable;
    logic [bdpc_pkg::PRESS_TIMER_BITS-1:0] n_press;
    logic                                  n_long_done;
    logic [bdpc_pkg::MODE_BITS-1:0]        n_mode;
    bdpc_pkg::t_event                      n_event;

    logic                                  settled;
    logic [bdpc_pkg::PRESS_TIMER_BITS-1:0] press_inc;
    logic [bdpc_pkg::MODE_BITS:0]          mode_inc;
    logic                                  press_short;
    logic                                  press_long;

    // Compute the next state for the sample in the input register
    always_comb begin
        press_inc = (r_press != PRESS_MAX) ? r_press + 1'b1 : r_press;

        if (i_level != r_prev_raw) begin
            n_change = '0;
        end else if (r_change != CHANGE_MAX) begin
            n_change = r_change + 1'b1;
        end else begin
            n_change = r_change;
        end

        settled     = n_change > i_cfg.debounce_ticks;
        press_short = bdpc_pkg::CMP_BITS'(press_inc)
                      < bdpc_pkg::CMP_BITS'(i_cfg.long_press_ticks);
        mode_inc    = {1'b0, r_mode} + 1'b1;

        n_stable    = r_stable;
        n_press     = press_inc;
        n_long_done = r_long_done;
        n_mode      = r_mode;
        n_event     = bdpc_pkg::EV_NONE;

        // Accept the new level; a press restarts the timer, a release may count
        if (settled && (i_level != r_stable)) begin
            n_stable = i_level;
            if (i_level == bdpc_pkg::LEVEL_PRESSED) begin
                n_press     = '0;
                n_long_done = 1'b0;
            end else if (!r_long_done && press_short) begin
                n_mode  = (mode_inc > {1'b0, i_cfg.last_mode}) ? '0
                          : mode_inc[bdpc_pkg::MODE_BITS-1:0];
                n_event = bdpc_pkg::EV_SHORT;
            end
        end

        // Report the long press once per press
        press_long = bdpc_pkg::CMP_BITS'(n_press)
                     >= bdpc_pkg::CMP_BITS'(i_cfg.long_press_ticks);
        if (settled && (n_stable == bdpc_pkg::LEVEL_PRESSED) && !n_long_done
            && press_long) begin
            n_long_done = 1'b1;
            n_event     = bdpc_pkg::EV_LONG;
        end

        o_result.event_kind   = n_event;
        o_result.mode_number  = n_mode;
        o_result.stable_level = n_stable;
    end

    // Commit state when the sample moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_raw  <= bdpc_pkg::LEVEL_RELEASED;
            r_change    <= '0;
            r_stable    <= bdpc_pkg::LEVEL_RELEASED;
            r_press     <= '0;
            r_long_done <= 1'b0;
            r_mode      <= '0;
        end else if (i_advance) begin
            r_prev_raw  <= i_level;
            r_change    <= n_change;
            r_stable    <= n_stable;
            r_press     <= n_press;
            r_long_done <= n_long_done;
            r_mode      <= n_mode;
        end
    end

endmodule
